FILE: hdl/asn_pkg.sv
`default_nettype none
package asn_pkg;

  localparam int MAX_LEN = 32;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int SEED_W  = 32;
  localparam int STEP_W  = $clog2(SEED_W);

  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_LEN);
  localparam logic [SEED_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [SEED_W-1:0] LCG_ADD = 32'd1013904223;

  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_UPP_LO = 8'h41;
  localparam logic [7:0] CH_UPP_HI = 8'h5A;
  localparam logic [7:0] CH_LOW_LO = 8'h61;
  localparam logic [7:0] CH_LOW_HI = 8'h7A;

  function automatic logic is_alnum(input logic [7:0] c);
    logic r;
    r = ((c >= CH_DIG_LO) && (c <= CH_DIG_HI)) ||
        ((c >= CH_UPP_LO) && (c <= CH_UPP_HI)) ||
        ((c >= CH_LOW_LO) && (c <= CH_LOW_HI));
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/alnum_position_shuffler.sv
`default_nettype none
// operation: after the last byte transfer the alphanumerics are shuffled, one step per
//   alphanumeric from the highest index down; each step advances the generator, starts
//   the bit-serial modulo unit and waits on it, reads entries i and j and writes both
//   back swapped; emission of the string follows the last step
// throughput: one input byte per cycle while collecting; a new string is taken only once the previous one is emitted
// reset: synchronous active-high rst clears counts, flags, seed and sequencer;
//   the byte stores are not cleared and hold nothing until written
module alnum_position_shuffler (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [7:0]                 ch,
  input  wire logic                       last,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [7:0]                      ch_out,
  output logic                            last_out,
  output logic                            overflow,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [asn_pkg::SEED_W-1:0] cfg_data
);
  import asn_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;  // collecting bytes
  localparam logic [3:0] ST_MUL  = 4'd1;  // advance the generator
  localparam logic [3:0] ST_DST  = 4'd2;  // kick off the modulo
  localparam logic [3:0] ST_DIV  = 4'd3;  // wait for the modulo
  localparam logic [3:0] ST_RD   = 4'd4;  // read entries i and j
  localparam logic [3:0] ST_WI   = 4'd5;  // write entry i
  localparam logic [3:0] ST_WJ   = 4'd6;  // write entry j, step i down
  localparam logic [3:0] ST_ERD  = 4'd7;  // read next emitted position
  localparam logic [3:0] ST_ELD  = 4'd8;  // load the output register

  logic [3:0]        state;
  logic [SEED_W-1:0] seed;
  logic [SEED_W-1:0] seed_next;
  logic [CNT_W-1:0]  byte_count;
  logic [CNT_W-1:0]  alnum_count;
  logic [CNT_W-1:0]  alnum_count_next;
  logic              dropped;
  logic [IDX_W-1:0]  idx_i;
  logic [IDX_W-1:0]  idx_j;
  logic [CNT_W-1:0]  emit_k;
  logic [CNT_W-1:0]  emit_a;

  // byte stores, registered reads
  logic [7:0] byte_store  [MAX_LEN];
  logic [7:0] alnum_store [MAX_LEN];
  logic [7:0] byte_rd;
  logic [7:0] alnum_rd_a;
  logic [7:0] alnum_rd_b;

  logic             in_fire;
  logic             cfg_fire;
  logic             room;
  logic             ch_alnum;
  logic             rd_en;
  logic             as_we;
  logic [IDX_W-1:0] as_waddr;
  logic [7:0]       as_wdata;
  logic [IDX_W-1:0] as_raddr_a;
  logic             emit_go;
  logic             emit_alnum;

  logic             div_start;
  logic             div_done;
  logic [CNT_W-1:0] div_rem;

  assign in_ready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign room      = (byte_count < CNT_MAX);
  assign ch_alnum  = is_alnum(ch);

  // one lcg step: multiply registered before the modulo picks it up
  assign seed_next = seed * LCG_MUL + LCG_ADD;

  assign alnum_count_next = (room && ch_alnum) ? alnum_count + CNT_W'(1) : alnum_count;

  // shared modulo unit: seed mod (i+1)
  assign div_start = (state == ST_DST);

  asn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (seed),
    .divisor  (CNT_W'(idx_i) + CNT_W'(1)),
    .done     (div_done),
    .rem      (div_rem)
  );

  // alnum store port muxing: collect writes, swap writes, swap and emit reads
  always_comb begin
    as_we      = 1'b0;
    as_waddr   = alnum_count[IDX_W-1:0];
    as_wdata   = ch;
    as_raddr_a = idx_i;
    rd_en      = 1'b0;
    case (state)
      ST_IDLE: begin
        as_we = in_fire & room & ch_alnum;
      end
      ST_RD: begin
        rd_en = 1'b1;
      end
      ST_WI: begin
        as_we    = 1'b1;
        as_waddr = idx_i;
        as_wdata = alnum_rd_b;
      end
      ST_WJ: begin
        as_we    = 1'b1;
        as_waddr = idx_j;
        as_wdata = alnum_rd_a;
      end
      ST_ERD: begin
        rd_en      = 1'b1;
        as_raddr_a = emit_a[IDX_W-1:0];
      end
      default: begin
        as_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && room) begin
      byte_store[byte_count[IDX_W-1:0]] <= ch;
    end
    if (as_we) begin
      alnum_store[as_waddr] <= as_wdata;
    end
    if (rd_en) begin
      byte_rd    <= byte_store[emit_k[IDX_W-1:0]];
      alnum_rd_a <= alnum_store[as_raddr_a];
      alnum_rd_b <= alnum_store[idx_j];
    end
  end

  // output register takes a byte when empty or being drained
  assign emit_go    = (state == ST_ELD) && (!out_valid || out_ready);
  assign emit_alnum = is_alnum(byte_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      seed        <= '0;
      byte_count  <= '0;
      alnum_count <= '0;
      dropped     <= 1'b0;
      out_valid   <= 1'b0;
      idx_i       <= '0;
      idx_j       <= '0;
      emit_k      <= '0;
      emit_a      <= '0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (cfg_fire) begin
        seed <= cfg_data;
      end else if (state == ST_MUL) begin
        seed <= seed_next;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (room) begin
              byte_count  <= byte_count + CNT_W'(1);
              alnum_count <= alnum_count_next;
            end else begin
              dropped <= 1'b1;
            end
            if (last) begin
              emit_k <= '0;
              emit_a <= '0;
              idx_i  <= IDX_W'(alnum_count_next - CNT_W'(1));
              // no alphanumerics: nothing to shuffle
              state  <= (alnum_count_next == '0) ? ST_ERD : ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state <= ST_DST;
        end
        ST_DST: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            idx_j <= div_rem[IDX_W-1:0];
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_WI;
        end
        ST_WI: begin
          state <= ST_WJ;
        end
        ST_WJ: begin
          // step for index zero still runs, then emission starts
          if (idx_i == '0) begin
            state <= ST_ERD;
          end else begin
            idx_i <= idx_i - IDX_W'(1);
            state <= ST_MUL;
          end
        end
        ST_ERD: begin
          state <= ST_ELD;
        end
        ST_ELD: begin
          if (emit_go) begin
            emit_k <= emit_k + CNT_W'(1);
            if (emit_alnum) begin
              emit_a <= emit_a + CNT_W'(1);
            end
            if ((emit_k + CNT_W'(1)) == byte_count) begin
              byte_count  <= '0;
              alnum_count <= '0;
              dropped     <= 1'b0;
              state       <= ST_IDLE;
            end else begin
              state <= ST_ERD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit_go) begin
      ch_out   <= emit_alnum ? alnum_rd_a : byte_rd;
      last_out <= ((emit_k + CNT_W'(1)) == byte_count);
      overflow <= dropped;
    end
  end

`ifndef SYNTH
  a_count_order: assert property (@(posedge clk) disable iff (rst)
    alnum_count <= byte_count)
    else $error("alnum count exceeds byte count");
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    byte_count <= CNT_MAX)
    else $error("byte count beyond capacity");
  a_swap_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (idx_j <= idx_i))
    else $error("swap partner above current index");
  a_emit_alnum: assert property (@(posedge clk) disable iff (rst)
    (emit_go && emit_alnum) |-> (emit_a < alnum_count))
    else $error("emission ran past the shuffled set");
`endif
endmodule
`default_nettype wire

FILE: hdl/asn_div.sv
`default_nettype none
module asn_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [asn_pkg::SEED_W-1:0] dividend,
  input  wire logic [asn_pkg::CNT_W-1:0]  divisor,
  output logic                           done,
  output logic [asn_pkg::CNT_W-1:0]       rem
);
  import asn_pkg::*;

  // restoring remainder, one dividend bit per cycle
  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [SEED_W-1:0] dvd;
  logic [CNT_W-1:0]  dvs;
  logic [CNT_W:0]    trial;
  logic [CNT_W-1:0]  rem_next;

  assign trial = {rem, dvd[SEED_W-1]};

  always_comb begin
    if (trial >= {1'b0, dvs}) begin
      rem_next = CNT_W'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + STEP_W'(1);
        if (cnt == STEP_W'(SEED_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd << 1;
      rem <= rem_next;
    end
  end

`ifndef SYNTH
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while busy");
  a_rem_range: assert property (@(posedge clk) disable iff (rst) done |-> (rem < dvs))
    else $error("remainder not below divisor");
`endif
endmodule
`default_nettype wire
